### design/ptp_pkg.sv
// ptp_pkg: shared constants, configuration register codes and latency helpers
// for the point-to-triangle projection pipeline. No dependencies.
`default_nettype none

package ptp_pkg;

    // default coordinate width (signed fixed point)
    localparam int COORD_WIDTH_DEF = 32;

    // operand slice of one partial-product multiplier
    localparam int MUL_CHUNK = 32;

    // extra fraction bits of the square root ahead of the gap quotient
    localparam int SQRT_GUARD = 24;

    // fraction bits of the tolerance, barycentric weights are scaled by this
    localparam int INSIDE_SHIFT = 30;

    // configuration register widths and reset values
    localparam int CFG_DATA_WIDTH = 32;
    localparam int EPS_WIDTH      = 32;
    localparam int TOL_WIDTH      = 30;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd1;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 30'd0;

    // configuration register index codes
    typedef enum logic
    {
        CFG_AREA_EPSILON     = 1'b0,
        CFG_INSIDE_TOLERANCE = 1'b1
    } cfg_index_t;

    // number of multiplier slices that cover a w-bit operand
    function automatic int chunk_count(input int w);
        return (w + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

    // latency of ptp_mult: magnitude stage, one stage per partial product, sign stage
    function automatic int mul_latency(input int wa, input int wb);
        return chunk_count(wa) * chunk_count(wb) + 2;
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

### design/point_triangle_projection_top.sv
// point_triangle_projection_top: projects a point onto a triangle's plane, gives the
// foot point, the signed gap and the barycentric inside flag. Depends on ptp_pkg,
// ptp_mult and ptp_rdiv.
//
//   channel   signals                                   transfer
//   -------   ---------------------------------------   ------------------------------
//   input     start, busy, point_*, vert_a/b/c_*        edge with start high, busy low
//   result    done, valid_res, foot_*, gap, inside_res  edge ending the cycle done is high
//   config    cfg_we, cfg_index, cfg_wdata              edge with cfg_we high
//
// One item enters per cycle; busy is always low. The item passes two multiplier
// pipelines (cross product, squared normal), then the square root with one root bit
// per stage, then the gap divider with one quotient bit per stage. Reset clears the
// valid line and sets the configuration registers to their reset values.
// The receiver cannot stall, so every result is shown for exactly one cycle.
`default_nettype none

module point_triangle_projection_top
    import ptp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] point_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_z,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]     cfg_wdata,
    output logic                               done,
    output logic                               valid_res,
    output logic signed [COORD_WIDTH-1:0]      foot_x,
    output logic signed [COORD_WIDTH-1:0]      foot_y,
    output logic signed [COORD_WIDTH-1:0]      foot_z,
    output logic signed [COORD_WIDTH-1:0]      gap,
    output logic                               inside_res
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;               // vertex differences
    localparam int NW  = 2 * DW + 1;           // normal components
    localparam int N2W = 2 * NW;               // squared normal, unsigned
    localparam int TW  = DW + NW + 1;          // AP . N
    localparam int VW  = 2 * NW + 4;           // barycentric numerators
    localparam int FW  = NW + TW;              // N_i * t
    localparam int TNW = TOL_WIDTH + N2W + 2;  // tolerance * n2
    localparam int CKW = imax(VW + INSIDE_SHIFT, TNW) + 1;

    localparam int L1 = mul_latency(DW, DW);
    localparam int L2 = mul_latency(NW, NW);
    localparam int L4 = mul_latency(NW, TW);
    localparam int L5 = mul_latency(TOL_WIDTH + 1, N2W + 1);

    localparam int QB  = CW + 3;
    localparam int QW  = QB + 1;
    localparam int LD  = QB + 2;
    localparam int SXW = N2W + 2 * SQRT_GUARD;
    localparam int RW  = SXW / 2;
    localparam int FDW = CW + 5;

    // stage times, counted in cycles after the input transfer
    localparam int T1   = 1;
    localparam int T2   = T1 + L1 + 1;
    localparam int T3   = T2 + L2 + 1;
    localparam int TQG  = T3 + RW + LD;
    localparam int TI   = T3 + L5 + 1;
    localparam int TOUT = TQG + 1;
    localparam int DP   = TQG - T1;
    localparam int DD   = TQG - T3 - 1;
    localparam int DQ   = RW - L4;
    localparam int DI   = TQG - TI;

    // configuration registers
    logic [EPS_WIDTH-1:0] eps_reg;
    logic [TOL_WIDTH-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AREA_EPSILON:     eps_reg <= cfg_wdata[EPS_WIDTH-1:0];
                CFG_INSIDE_TOLERANCE: tol_reg <= cfg_wdata[TOL_WIDTH-1:0];
                default:              eps_reg <= eps_reg;
            endcase
        end
    end

    // every cycle can take an item
    assign busy = 1'b0;

    // valid line
    logic [TOUT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOUT-2:0], start & ~busy};
        end
    end

    // stage 1: vertex differences
    logic signed [CW-1:0] p_in [3];
    logic signed [CW-1:0] a_in [3];
    logic signed [CW-1:0] b_in [3];
    logic signed [CW-1:0] c_in [3];

    assign p_in[0] = point_x;
    assign p_in[1] = point_y;
    assign p_in[2] = point_z;
    assign a_in[0] = vert_a_x;
    assign a_in[1] = vert_a_y;
    assign a_in[2] = vert_a_z;
    assign b_in[0] = vert_b_x;
    assign b_in[1] = vert_b_y;
    assign b_in[2] = vert_b_z;
    assign c_in[0] = vert_c_x;
    assign c_in[1] = vert_c_y;
    assign c_in[2] = vert_c_z;

    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic signed [DW-1:0] ap_reg [3];
    logic signed [CW-1:0] p_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab_reg[i] <= DW'(b_in[i]) - DW'(a_in[i]);
            ac_reg[i] <= DW'(c_in[i]) - DW'(a_in[i]);
            ap_reg[i] <= DW'(p_in[i]) - DW'(a_in[i]);
            p_reg[i]  <= p_in[i];
        end
    end

    // cross products: N = AB x AC, CV = AP x AC, CW = AB x AP
    logic signed [2*DW-1:0] nx [3];
    logic signed [2*DW-1:0] ny [3];
    logic signed [2*DW-1:0] vx [3];
    logic signed [2*DW-1:0] vy [3];
    logic signed [2*DW-1:0] wx [3];
    logic signed [2*DW-1:0] wy [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        ptp_mult #(.WA(DW), .WB(DW)) u_nx (.clk(clk), .a(ab_reg[J]), .b(ac_reg[K]), .p(nx[i]));
        ptp_mult #(.WA(DW), .WB(DW)) u_ny (.clk(clk), .a(ab_reg[K]), .b(ac_reg[J]), .p(ny[i]));
        ptp_mult #(.WA(DW), .WB(DW)) u_vx (.clk(clk), .a(ap_reg[J]), .b(ac_reg[K]), .p(vx[i]));
        ptp_mult #(.WA(DW), .WB(DW)) u_vy (.clk(clk), .a(ap_reg[K]), .b(ac_reg[J]), .p(vy[i]));
        ptp_mult #(.WA(DW), .WB(DW)) u_wx (.clk(clk), .a(ab_reg[J]), .b(ap_reg[K]), .p(wx[i]));
        ptp_mult #(.WA(DW), .WB(DW)) u_wy (.clk(clk), .a(ab_reg[K]), .b(ap_reg[J]), .p(wy[i]));
    end

    logic signed [NW-1:0] nv_reg [3];
    logic signed [NW-1:0] cv_reg [3];
    logic signed [NW-1:0] cw_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv_reg[i] <= NW'(nx[i]) - NW'(ny[i]);
            cv_reg[i] <= NW'(vx[i]) - NW'(vy[i]);
            cw_reg[i] <= NW'(wx[i]) - NW'(wy[i]);
        end
    end

    // AP held until the normal is ready
    logic signed [DW-1:0] ap_dly [L1+1][3];

    always_ff @(posedge clk)
    begin
        ap_dly[0] <= ap_reg;
        for (int s = 1; s <= L1; s++)
        begin
            ap_dly[s] <= ap_dly[s-1];
        end
    end

    // dot products with the normal
    logic signed [2*NW-1:0] sq [3];
    logic signed [2*NW-1:0] tp [3];
    logic signed [2*NW-1:0] vp [3];
    logic signed [2*NW-1:0] wp [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        ptp_mult #(.WA(NW), .WB(NW)) u_sq
            (.clk(clk), .a(nv_reg[i]), .b(nv_reg[i]), .p(sq[i]));
        ptp_mult #(.WA(NW), .WB(NW)) u_tp
            (.clk(clk), .a(NW'(ap_dly[L1][i])), .b(nv_reg[i]), .p(tp[i]));
        ptp_mult #(.WA(NW), .WB(NW)) u_vp
            (.clk(clk), .a(cv_reg[i]), .b(nv_reg[i]), .p(vp[i]));
        ptp_mult #(.WA(NW), .WB(NW)) u_wp
            (.clk(clk), .a(cw_reg[i]), .b(nv_reg[i]), .p(wp[i]));
    end

    logic [N2W-1:0]       n2_reg;
    logic signed [TW-1:0] t_reg;
    logic signed [VW-1:0] vn_reg;
    logic signed [VW-1:0] wn_reg;

    always_ff @(posedge clk)
    begin
        n2_reg <= $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
        t_reg  <= TW'(tp[0]) + TW'(tp[1]) + TW'(tp[2]);
        vn_reg <= VW'(vp[0]) + VW'(vp[1]) + VW'(vp[2]);
        wn_reg <= VW'(wp[0]) + VW'(wp[1]) + VW'(wp[2]);
    end

    // normal held until the sums are ready
    logic signed [NW-1:0] nv_dly [L2+1][3];

    always_ff @(posedge clk)
    begin
        nv_dly[0] <= nv_reg;
        for (int s = 1; s <= L2; s++)
        begin
            nv_dly[s] <= nv_dly[s-1];
        end
    end

    // degenerate test, one threshold covers both n2 and the denominator
    logic deg_reg;
    logic deg_dly [DD];

    always_ff @(posedge clk)
    begin
        deg_reg    <= (n2_reg == '0) || (n2_reg < N2W'(eps_reg));
        deg_dly[0] <= deg_reg;
        for (int s = 1; s < DD; s++)
        begin
            deg_dly[s] <= deg_dly[s-1];
        end
    end

    // foot offsets: N_i * t / n2
    logic signed [FW-1:0] fm [3];
    logic signed [QW-1:0] qf [3];
    logic [N2W-1:0]       n2f_dly [L4];

    always_ff @(posedge clk)
    begin
        n2f_dly[0] <= n2_reg;
        for (int s = 1; s < L4; s++)
        begin
            n2f_dly[s] <= n2f_dly[s-1];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_foot
        ptp_mult #(.WA(NW), .WB(TW)) u_fm
            (.clk(clk), .a(nv_dly[L2][i]), .b(t_reg), .p(fm[i]));
        ptp_rdiv #(.NUMW(FW), .DENW(N2W), .QB(QB)) u_fdiv
            (.clk(clk), .num(fm[i]), .den(n2f_dly[L4-1]), .quo(qf[i]));
    end

    logic signed [QW-1:0] qf_dly [DQ][3];

    always_ff @(posedge clk)
    begin
        qf_dly[0] <= qf;
        for (int s = 1; s < DQ; s++)
        begin
            qf_dly[s] <= qf_dly[s-1];
        end
    end

    // square root of n2 * 2^(2*guard), one root bit per stage
    logic [SXW-1:0] sq_rad_reg  [RW];
    logic [RW+1:0]  sq_rem_reg  [RW];
    logic [RW-1:0]  sq_root_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [SXW-1:0] rad_in;
        logic [RW+1:0]  rem_in;
        logic [RW+1:0]  rem_sh;
        logic [RW+1:0]  trial;
        logic [RW-1:0]  root_in;
        logic           fits;

        if (k == 0)
        begin : g_first
            assign rad_in  = {n2_reg, {(2*SQRT_GUARD){1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = sq_rad_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-1:0], rad_in[SXW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            sq_rad_reg[k]  <= rad_in << 2;
            sq_rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
            sq_root_reg[k] <= {root_in[RW-2:0], fits};
        end
    end

    // gap: t * 2^guard / root
    logic signed [TW-1:0] t_dly [RW];
    logic signed [QW-1:0] qg;

    always_ff @(posedge clk)
    begin
        t_dly[0] <= t_reg;
        for (int s = 1; s < RW; s++)
        begin
            t_dly[s] <= t_dly[s-1];
        end
    end

    ptp_rdiv #(.NUMW(TW + SQRT_GUARD), .DENW(RW), .QB(QB)) u_gdiv
    (
        .clk (clk),
        .num ({t_dly[RW-1], {SQRT_GUARD{1'b0}}}),
        .den (sq_root_reg[RW-1]),
        .quo (qg)
    );

    // inside test: each weight * 2^30 + tolerance * n2 >= 0
    logic signed [TNW-1:0] tn;
    logic signed [VW-1:0]  uvw_reg [3];
    logic signed [VW-1:0]  uvw_dly [L5-1][3];
    logic signed [CKW-1:0] chk [3];
    logic                  ins_reg;
    logic                  ins_dly [DI];

    ptp_mult #(.WA(TOL_WIDTH + 1), .WB(N2W + 1)) u_tol
        (.clk(clk), .a({1'b0, tol_reg}), .b({1'b0, n2_reg}), .p(tn));

    always_ff @(posedge clk)
    begin
        uvw_reg[0] <= VW'(n2_reg) - vn_reg - wn_reg;
        uvw_reg[1] <= vn_reg;
        uvw_reg[2] <= wn_reg;
        uvw_dly[0] <= uvw_reg;
        for (int s = 1; s < L5 - 1; s++)
        begin
            uvw_dly[s] <= uvw_dly[s-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            chk[i] = (CKW'(uvw_dly[L5-2][i]) <<< INSIDE_SHIFT) + CKW'(tn);
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg    <= ~chk[0][CKW-1] & ~chk[1][CKW-1] & ~chk[2][CKW-1];
        ins_dly[0] <= ins_reg;
        for (int s = 1; s < DI; s++)
        begin
            ins_dly[s] <= ins_dly[s-1];
        end
    end

    // query point held to the output stage
    logic signed [CW-1:0] p_dly [DP][3];

    always_ff @(posedge clk)
    begin
        p_dly[0] <= p_reg;
        for (int s = 1; s < DP; s++)
        begin
            p_dly[s] <= p_dly[s-1];
        end
    end

    // clamp to the coordinate range
    function automatic logic signed [CW-1:0] sat(input logic signed [FDW-1:0] x);
        logic fits;
        fits = (x[FDW-1:CW-1] == '0) || (x[FDW-1:CW-1] == '1);
        if (fits)
        begin
            return x[CW-1:0];
        end
        return x[FDW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    // output stage
    logic signed [FDW-1:0] foot_w [3];
    logic signed [CW-1:0]  foot_reg [3];
    logic signed [CW-1:0]  gap_reg;
    logic                  valid_reg;
    logic                  inside_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            foot_w[i] = FDW'(p_dly[DP-1][i]) - FDW'(qf_dly[DQ-1][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_dly[DD-1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                foot_reg[i] <= '0;
            end
            gap_reg    <= '0;
            valid_reg  <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                foot_reg[i] <= sat(foot_w[i]);
            end
            gap_reg    <= sat(FDW'(qg));
            valid_reg  <= 1'b1;
            inside_reg <= ins_dly[DI-1];
        end
    end

    assign done       = vld_reg[TOUT-1];
    assign valid_res  = valid_reg;
    assign foot_x     = foot_reg[0];
    assign foot_y     = foot_reg[1];
    assign foot_z     = foot_reg[2];
    assign gap        = gap_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

### design/ptp_mult.sv
// ptp_mult: pipelined signed multiplier built from MUL_CHUNK x MUL_CHUNK slices,
// one partial product per stage. Depends on ptp_pkg.
`default_nettype none

module ptp_mult
    import ptp_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
)
(
    input  wire logic                    clk,
    input  wire logic signed [WA-1:0]    a,
    input  wire logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0]      p
);

    localparam int NA  = chunk_count(WA);
    localparam int NB  = chunk_count(WB);
    localparam int NS  = NA * NB;
    localparam int AXW = NA * MUL_CHUNK;
    localparam int BXW = NB * MUL_CHUNK;
    localparam int AW  = AXW + BXW;
    localparam int PW  = WA + WB;

    logic [WA-1:0]  a_mag;
    logic [WB-1:0]  b_mag;
    logic [AXW-1:0] a_reg   [NS+1];
    logic [BXW-1:0] b_reg   [NS+1];
    logic [AW-1:0]  acc_reg [NS+1];
    logic           neg_reg [NS+1];
    logic [PW-1:0]  p_reg;

    // magnitudes of the operands
    always_comb
    begin
        a_mag = a[WA-1] ? ($unsigned(~a) + 1'b1) : $unsigned(a);
        b_mag = b[WB-1] ? ($unsigned(~b) + 1'b1) : $unsigned(b);
    end

    always_ff @(posedge clk)
    begin
        a_reg[0]   <= AXW'(a_mag);
        b_reg[0]   <= BXW'(b_mag);
        acc_reg[0] <= '0;
        neg_reg[0] <= a[WA-1] ^ b[WB-1];
    end

    // one slice product accumulated per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int I = k / NB;
        localparam int J = k % NB;
        logic [2*MUL_CHUNK-1:0] pp;

        assign pp = a_reg[k][I*MUL_CHUNK +: MUL_CHUNK] * b_reg[k][J*MUL_CHUNK +: MUL_CHUNK];

        always_ff @(posedge clk)
        begin
            a_reg[k+1]   <= a_reg[k];
            b_reg[k+1]   <= b_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            acc_reg[k+1] <= acc_reg[k] + (AW'(pp) << ((I + J) * MUL_CHUNK));
        end
    end

    // restore the sign
    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg[NS] ? (~acc_reg[NS][PW-1:0] + 1'b1) : acc_reg[NS][PW-1:0];
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### design/ptp_rdiv.sv
// ptp_rdiv: pipelined divider, signed numerator by unsigned divisor, quotient
// rounded to nearest with ties away from zero, one quotient bit per stage. Depends on ptp_pkg.
`default_nettype none

module ptp_rdiv
    import ptp_pkg::*;
#(
    parameter int NUMW = 64,
    parameter int DENW = 32,
    parameter int QB   = 35
)
(
    input  wire logic                  clk,
    input  wire logic signed [NUMW-1:0] num,
    input  wire logic [DENW-1:0]       den,
    output logic signed [QB:0]         quo
);

    localparam int QW = QB + 1;
    localparam int XW = imax(NUMW + 2, DENW + QB + 2);

    logic [NUMW-1:0] num_mag;
    logic [XW-1:0]   rem_reg [QB+1];
    logic [XW-1:0]   dvs_reg [QB+1];
    logic [QB-1:0]   quo_reg [QB+1];
    logic            neg_reg [QB+1];
    logic [QW-1:0]   out_reg;

    assign num_mag = num[NUMW-1] ? ($unsigned(~num) + 1'b1) : $unsigned(num);

    // rounding: floor((2|n| + d) / (2d))
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= (XW'(num_mag) << 1) + XW'(den);
        dvs_reg[0] <= XW'(den) << 1;
        quo_reg[0] <= '0;
        neg_reg[0] <= num[NUMW-1];
    end

    // restoring steps, most significant quotient bit first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int B = QB - 1 - k;
        logic [XW-1:0] trial;
        logic          fits;

        assign trial = dvs_reg[k] << B;
        assign fits  = rem_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= fits ? (rem_reg[k] - trial) : rem_reg[k];
            dvs_reg[k+1] <= dvs_reg[k];
            quo_reg[k+1] <= {quo_reg[k][QB-2:0], fits};
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= neg_reg[QB] ? (~{1'b0, quo_reg[QB]} + 1'b1) : {1'b0, quo_reg[QB]};
    end

    assign quo = out_reg;

endmodule

`default_nettype wire
